// ----- sv/hvd_pkg.sv -----
// Shared constants, types and the arctangent table of the haversine distance pipeline.
`timescale 1ns / 1ps

package hvd_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int SQRT_STEPS   = 31;
  localparam int LATENCY      = 12 + SQRT_STEPS + 2 * CORDIC_STEPS;

  localparam int CW = 34;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic [30:0]          q_t;

  localparam q_t          Q_ONE        = 31'h4000_0000;
  localparam logic [61:0] PROD_HALF    = 62'h2000_0000;
  localparam cw_t         GAIN_Q30     = 34'sd652032874;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [32:0] HALF_TURN    = 33'd3600000000;
  localparam logic [32:0] QUARTER_TURN = 33'd1800000000;
  localparam logic [31:0] RECIP        = 32'((64'(PI_Q30) << 32) / 64'(HALF_TURN));
  localparam logic [32:0] DIAM_CM_Q2   = 33'd5098238049;
  localparam logic [30:0] DIST_MAX     = 31'd2002074200;
  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [30:0] LAT_MIN = -31'sd900000000;

  function automatic cw_t atan_entry(input int i);
    cw_t r;
    r = '0;
    if (i < 10) begin
      unique case (i)
        0:       r = 34'sd843314856;
        1:       r = 34'sd497837829;
        2:       r = 34'sd263043836;
        3:       r = 34'sd133525158;
        4:       r = 34'sd67021686;
        5:       r = 34'sd33543515;
        6:       r = 34'sd16775850;
        7:       r = 34'sd8388437;
        8:       r = 34'sd4194282;
        default: r = 34'sd2097149;
      endcase
    end else if (i < 30) begin
      r = (cw_t'(1) <<< (30 - i)) - cw_t'(1);
    end
    return r;
  endfunction

endpackage

// ----- sv/haversine_distance.sv -----
// Haversine great-circle distance, fully pipelined: one pair per cycle unless stalled.
//
// Channels: an input item (first_lat, first_lon, second_lat, second_lon, in units of
// 1e-7 degree) is taken when in_valid and in_ready are high at a clock edge. The
// result distance_cm (centimeters, rounded to nearest) is offered with out_valid and
// is taken when out_valid and out_ready are high.
// Throughput: one item per cycle while the output is not stalled. The depth of the
// pipeline is set by the two unrolled CORDIC rotators (one step a stage), the unrolled
// square root (one result bit a stage) and the constant division at the front
// (multiply by reciprocal, then correct).
// The pipeline keeps a valid bit per stage. All stages advance together whenever the
// output register is empty or being taken, so a stalled receiver freezes the whole
// pipe: nothing is lost or repeated, and in_ready drops until the result is taken.
// Bubbles in the pipe are not squeezed out; they move along with the items.
// Reset (rst, synchronous) clears the valid bits; no item is in flight afterward.
`timescale 1ns / 1ps

module haversine_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] first_lat,
  input  logic signed [31:0] first_lon,
  input  logic signed [30:0] second_lat,
  input  logic signed [31:0] second_lon,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        distance_cm
);

  localparam int N   = hvd_pkg::CORDIC_STEPS;
  localparam int S   = hvd_pkg::SQRT_STEPS;
  localparam int LAT = hvd_pkg::LATENCY;
  localparam int CW  = hvd_pkg::CW;

  logic en;
  logic [LAT-1:0] vld;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [30:0] lat1c, lat2c;
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic signed [30:0] alat1, alat2;
  logic [32:0]        hin [0:3];

  always_comb begin
    lat1c = first_lat;
    if (first_lat > hvd_pkg::LAT_MAX) begin
      lat1c = hvd_pkg::LAT_MAX;
    end else if (first_lat < hvd_pkg::LAT_MIN) begin
      lat1c = hvd_pkg::LAT_MIN;
    end
    lat2c = second_lat;
    if (second_lat > hvd_pkg::LAT_MAX) begin
      lat2c = hvd_pkg::LAT_MAX;
    end else if (second_lat < hvd_pkg::LAT_MIN) begin
      lat2c = hvd_pkg::LAT_MIN;
    end
    dlat  = 32'(lat1c) - 32'(lat2c);
    dlon  = 33'(first_lon) - 33'(second_lon);
    alat1 = lat1c[30] ? -lat1c : lat1c;
    alat2 = lat2c[30] ? -lat2c : lat2c;
    hin[0] = dlat[31] ? 33'(-dlat) : 33'(dlat);
    hin[1] = dlon[32] ? 33'(-dlon) : 33'(dlon);
    hin[2] = {2'b00, alat1[29:0], 1'b0};
    hin[3] = {2'b00, alat2[29:0], 1'b0};
  end

  logic [32:0]        h0  [0:3];
  logic [30:0]        rr  [0:3];
  logic [63:0]        tt  [0:3];
  logic [63:0]        tt2 [0:3];
  logic [30:0]        qa  [0:3];
  logic [30:0]        qa2 [0:3];
  logic [63:0]        mm  [0:3];
  hvd_pkg::cw_t       rx  [0:N][0:3];
  hvd_pkg::cw_t       ry  [0:N][0:3];
  hvd_pkg::cw_t       rz  [0:N][0:3];

  for (genvar j = 0; j < 4; j++) begin : g_front
    logic [32:0]        hm, hf;
    logic [63:0]        pr;
    logic signed [64:0] rem;
    hvd_pkg::cw_t       qz;

    assign hm  = (h0[j] >= hvd_pkg::HALF_TURN) ? h0[j] - hvd_pkg::HALF_TURN : h0[j];
    assign hf  = (hm > hvd_pkg::QUARTER_TURN) ? hvd_pkg::HALF_TURN - hm : hm;
    assign pr  = 64'(rr[j]) * 64'(hvd_pkg::RECIP) + 64'h8000_0000;
    assign rem = $signed({1'b0, tt2[j]}) - $signed({1'b0, mm[j]});
    assign qz  = hvd_pkg::cw_t'({3'b000, qa2[j]});

    always_ff @(posedge clk) begin
      if (en) begin
        h0[j]  <= hin[j];
        rr[j]  <= hf[30:0];
        tt[j]  <= 64'(rr[j]) * 64'(hvd_pkg::PI_Q30) + 64'(hvd_pkg::QUARTER_TURN);
        qa[j]  <= pr[62:32];
        tt2[j] <= tt[j];
        qa2[j] <= qa[j];
        mm[j]  <= 64'(qa[j]) * 64'(hvd_pkg::HALF_TURN);
        rx[0][j] <= hvd_pkg::GAIN_Q30;
        ry[0][j] <= '0;
        if (rem[64]) begin
          rz[0][j] <= qz - hvd_pkg::cw_t'(1);
        end else if (rem >= $signed({32'd0, hvd_pkg::HALF_TURN})) begin
          rz[0][j] <= qz + hvd_pkg::cw_t'(1);
        end else begin
          rz[0][j] <= qz;
        end
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    for (genvar j = 0; j < 4; j++) begin : g_lane
      hvd_pkg::cw_t dx, dy, t;
      assign dx = ry[k][j] >>> k;
      assign dy = rx[k][j] >>> k;
      assign t  = hvd_pkg::atan_entry(k);
      always_ff @(posedge clk) begin
        if (en) begin
          if (!rz[k][j][CW-1]) begin
            rx[k+1][j] <= rx[k][j] - dx;
            ry[k+1][j] <= ry[k][j] + dy;
            rz[k+1][j] <= rz[k][j] - t;
          end else begin
            rx[k+1][j] <= rx[k][j] + dx;
            ry[k+1][j] <= ry[k][j] - dy;
            rz[k+1][j] <= rz[k][j] + t;
          end
        end
      end
    end
  end

  hvd_pkg::q_t  sabs [0:1];
  hvd_pkg::q_t  cosv [0:1];
  hvd_pkg::q_t  sq   [0:1];
  hvd_pkg::q_t  cc, sl3, p2;
  logic [61:0]  sv   [0:S][0:1];
  logic [61:0]  sr   [0:S][0:1];

  for (genvar j = 0; j < 2; j++) begin : g_post
    hvd_pkg::cw_t sa, cv;
    logic [61:0]  ps;
    assign sa = ry[N][j][CW-1] ? -ry[N][j] : ry[N][j];
    assign cv = rx[N][j+2];
    assign ps = 62'(sabs[j]) * 62'(sabs[j]) + hvd_pkg::PROD_HALF;
    always_ff @(posedge clk) begin
      if (en) begin
        sabs[j] <= (sa > hvd_pkg::cw_t'(hvd_pkg::Q_ONE)) ? hvd_pkg::Q_ONE : sa[30:0];
        if (cv[CW-1]) begin
          cosv[j] <= '0;
        end else if (cv > hvd_pkg::cw_t'(hvd_pkg::Q_ONE)) begin
          cosv[j] <= hvd_pkg::Q_ONE;
        end else begin
          cosv[j] <= cv[30:0];
        end
        sq[j] <= ps[60:30];
      end
    end
  end

  logic [61:0] pc, pa;
  logic [31:0] asum;
  hvd_pkg::q_t aq;

  assign pc   = 62'(cosv[0]) * 62'(cosv[1]) + hvd_pkg::PROD_HALF;
  assign pa   = 62'(cc) * 62'(sq[1]) + hvd_pkg::PROD_HALF;
  assign asum = 32'(sl3) + 32'(p2);
  assign aq   = (asum > 32'(hvd_pkg::Q_ONE)) ? hvd_pkg::Q_ONE : asum[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      cc       <= pc[60:30];
      sl3      <= sq[0];
      p2       <= pa[60:30];
      sv[0][0] <= {1'b0, aq, 30'd0};
      sv[0][1] <= {1'b0, hvd_pkg::Q_ONE - aq, 30'd0};
      sr[0][0] <= '0;
      sr[0][1] <= '0;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [61:0] trial;
      assign trial = sr[k][j] + BIT;
      always_ff @(posedge clk) begin
        if (en) begin
          if (sv[k][j] >= trial) begin
            sv[k+1][j] <= sv[k][j] - trial;
            sr[k+1][j] <= (sr[k][j] >> 1) + BIT;
          end else begin
            sv[k+1][j] <= sv[k][j];
            sr[k+1][j] <= sr[k][j] >> 1;
          end
        end
      end
    end
  end

  hvd_pkg::cw_t vx [0:N];
  hvd_pkg::cw_t vy [0:N];
  hvd_pkg::cw_t vz [0:N];
  logic [61:0]  rq, rp;

  assign rq = sr[S][0] + 62'(sv[S][0] > sr[S][0]);
  assign rp = sr[S][1] + 62'(sv[S][1] > sr[S][1]);

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0] <= hvd_pkg::cw_t'(rp[32:0]);
      vy[0] <= hvd_pkg::cw_t'(rq[32:0]);
      vz[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_vec
    hvd_pkg::cw_t dx, dy, t;
    assign dx = vy[k] >>> k;
    assign dy = vx[k] >>> k;
    assign t  = hvd_pkg::atan_entry(k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy[k][CW-1]) begin
          vx[k+1] <= vx[k] + dx;
          vy[k+1] <= vy[k] - dy;
          vz[k+1] <= vz[k] + t;
        end else begin
          vx[k+1] <= vx[k] - dx;
          vy[k+1] <= vy[k] + dy;
          vz[k+1] <= vz[k] - t;
        end
      end
    end
  end

  logic [30:0] theta;
  logic [63:0] dprod;
  logic [64:0] dround;

  assign theta  = vz[N][CW-1] ? 31'd0 : vz[N][30:0];
  assign dround = 65'(dprod) + 65'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      dprod <= 64'(theta) * 64'(hvd_pkg::DIAM_CM_Q2);
      if (dround[64:32] > 33'(hvd_pkg::DIST_MAX)) begin
        distance_cm <= hvd_pkg::DIST_MAX;
      end else begin
        distance_cm <= dround[62:32];
      end
    end
  end

endmodule

// ----- sv/hvd_checker.sv -----
// Port-level checks of the haversine distance pipeline, bound to the top level.
`timescale 1ns / 1ps

module hvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] distance_cm
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_cm <= hvd_pkg::DIST_MAX)
    else $error("distance above limit");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);

// ----- verif/haversine_distance_checker.sv -----
// Distance predictor and result checker for the haversine distance block.
`timescale 1ns / 1ps

module haversine_distance_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [30:0] first_lat,
  input  logic signed [31:0] first_lon,
  input  logic signed [30:0] second_lat,
  input  logic signed [31:0] second_lon,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [30:0]        distance_cm,
  output int                 error_count,
  output int                 pending_count,
  output int                 checked_count
);

  logic [30:0] distance_queue[$];

  function automatic longint arc_step(input int i);
    if (i < 10) begin
      case (i)
        0: return 843314856;
        1: return 497837829;
        2: return 263043836;
        3: return 133525158;
        4: return 67021686;
        5: return 33543515;
        6: return 16775850;
        7: return 8388437;
        8: return 4194282;
        default: return 2097149;
      endcase
    end
    if (i < 30) return (64'sd1 << (30 - i)) - 1;
    return 0;
  endfunction

  function automatic longint half_to_q30(input longint h);
    longint r;
    r = h % 64'sd3600000000;
    if (r > 64'sd1800000000) r = 64'sd3600000000 - r;
    return (r * 64'sd3373259426 + 64'sd1800000000) / 64'sd3600000000;
  endfunction

  function automatic void rotate_unit(input longint angle, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = angle;
    for (int i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint sine_squared(input longint h);
    longint c, s;
    rotate_unit(half_to_q30(h), c, s);
    if (s < 0) s = -s;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return q30_mul(s, s);
  endfunction

  function automatic longint cosine_of_lat(input longint lat);
    longint c, s;
    rotate_unit(half_to_q30((lat < 0 ? -lat : lat) * 2), c, s);
    if (c < 0) c = 0;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    return c;
  endfunction

  function automatic longint q30_root(input longint a);
    logic [63:0] v, res, b;
    v = 64'(a) << 30;
    res = 0;
    b = 64'd1 << 60;
    for (int k = 0; k < 31; k++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (v > res) res = res + 1;
    return longint'(res);
  endfunction

  function automatic longint arc_of(input longint xin, input longint yin);
    longint x, y, z, dx, dy;
    x = xin;
    y = yin;
    z = 0;
    for (int i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_step(i);
      end else begin
        x -= dx; y += dy; z -= arc_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint clamp_latitude(input longint v);
    if (v > 900000000) return 900000000;
    if (v < -900000000) return -900000000;
    return v;
  endfunction

  function automatic logic [30:0] predict_distance(input longint la1, input longint lo1,
                                                   input longint la2, input longint lo2);
    longint l1, l2, dlat, dlon, sl, so, cc, a, theta;
    logic [127:0] d;
    l1 = clamp_latitude(la1);
    l2 = clamp_latitude(la2);
    dlat = l1 - l2;
    dlon = lo1 - lo2;
    sl = sine_squared(dlat < 0 ? -dlat : dlat);
    so = sine_squared(dlon < 0 ? -dlon : dlon);
    cc = q30_mul(cosine_of_lat(l1), cosine_of_lat(l2));
    a = sl + q30_mul(cc, so);
    if (a > 64'sd1073741824) a = 64'sd1073741824;
    theta = arc_of(q30_root(64'sd1073741824 - a), q30_root(a));
    if (theta < 0) theta = 0;
    d = (128'(theta) * 128'd5098238049 + (128'd1 << 31)) >> 32;
    if (d > 128'd2002074200) d = 128'd2002074200;
    return d[30:0];
  endfunction

  assign pending_count = distance_queue.size();

  always_ff @(posedge clk) begin
    logic [30:0] want;
    if (rst) begin
      error_count <= 0;
      checked_count <= 0;
    end else begin
      if (in_valid && in_ready)
        distance_queue.push_back(predict_distance(first_lat, first_lon, second_lat,
                                                  second_lon));
      if (out_valid && out_ready) begin
        checked_count <= checked_count + 1;
        if (distance_queue.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10) $display("unexpected distance_cm %0d", distance_cm);
        end else begin
          want = distance_queue.pop_front();
          if (want !== distance_cm) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("distance_cm mismatch: expected %0d, got %0d", want, distance_cm);
          end
        end
      end
    end
  end
endmodule

// ----- verif/haversine_distance_tb.sv -----
// Top of the haversine distance testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module haversine_distance_tb;
  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [30:0] first_lat = 0;
  logic signed [31:0] first_lon = 0;
  logic signed [30:0] second_lat = 0;
  logic signed [31:0] second_lon = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [30:0]        distance_cm;
  int                 error_count, pending_count, checked_count;
  int                 cycle_count = 0;
  bit                 quiet = 0;
  int                 sent = 0;

  haversine_distance i_dut (.*);
  haversine_distance_checker i_checker (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk)
    if (!rst) out_ready <= quiet || ($urandom_range(99) >= 30);

  function automatic logic signed [30:0] any_lat();
    case ($urandom_range(9))
      0: return 31'($urandom);
      1: return $urandom_range(1) ? 31'sd900000000 : -31'sd900000000;
      default: return 31'($signed($urandom_range(1800000000)) - 900000000);
    endcase
  endfunction

  function automatic logic signed [31:0] any_lon();
    case ($urandom_range(9))
      0: return 32'($urandom);
      1: return $urandom_range(1) ? 32'sd1800000000 : -32'sd1800000000;
      default: return $signed($urandom_range(3600000000)) - 32'sd1800000000;
    endcase
  endfunction

  task automatic send_pair(input logic signed [30:0] la1, input logic signed [31:0] lo1,
                           input logic signed [30:0] la2, input logic signed [31:0] lo2);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    first_lat <= la1;
    first_lon <= lo1;
    second_lat <= la2;
    second_lon <= lo2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    logic signed [30:0] la;
    logic signed [31:0] lo;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_pair(0, 0, 0, 0);
    send_pair(900000000, 0, -900000000, 0);
    send_pair(-900000000, 0, 900000000, 0);
    send_pair(0, 0, 0, 1800000000);
    send_pair(0, -1800000000, 0, 1800000000);
    send_pair(0, 2147483647, 0, -2147483648);
    send_pair(1073741823, 0, -1073741824, 0);
    send_pair(950000000, 10, -950000000, -10);
    send_pair(0, 0, 0, 900000000);
    send_pair(0, 0, 0, 1);
    send_pair(1, 0, 0, 0);
    send_pair(899999999, 0, 899999999, 1800000000);
    send_pair(450000000, 0, -450000000, 1800000000);
    send_pair(-1, -1, -1, -1);
    send_pair(0, 0, 0, 2700000000);
    send_pair(123456789, -987654321, -123456789, 987654321);
    for (int n = 0; n < 1900; n++) begin
      quiet = (n >= 600 && n < 900);
      if ($urandom_range(3) == 0) begin
        la = any_lat();
        lo = any_lon();
        send_pair(la, lo, 31'(la + $signed($urandom_range(2000)) - 1000),
                  lo + $signed($urandom_range(2000)) - 1000);
      end else begin
        send_pair(any_lat(), any_lon(), any_lat(), any_lon());
      end
    end
    quiet = 0;
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d point pairs, checked %0d distances", sent, checked_count);
    $display("Covered pole, antimeridian, out-of-range latitude and near-point cases");
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
